// File: sv/b64d_pkg.sv
// b64d_pkg: shared types, constants and functions of the base64 stream decoder
// no dependencies; imported by every module of the block
`default_nettype none

package b64d_pkg;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = $clog2(QDepth);
    localparam int unsigned QCntW  = $clog2(QDepth + 1);

    localparam logic [7:0] CH_PAD   = 8'h3d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_LOWER = 8'h61;
    localparam logic [7:0] CH_DIGIT = 8'h30;
    localparam logic [7:0] VAL_BAD  = 8'hff;

    localparam logic [7:0] MASK_HI2 = 8'h30;
    localparam logic [7:0] MASK_LO4 = 8'h0f;
    localparam logic [7:0] MASK_MID = 8'h3c;
    localparam logic [7:0] MASK_LO2 = 8'h03;

    // one step's worth of results: one to three bytes or a bare end marker
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            has_data;
        logic            eos;
        logic            err;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [7:0] value;
        logic       bad;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet s;
        s.bad = 1'b0;
        if (c inside {[8'h41:8'h5a]}) begin
            s.value = c - CH_UPPER;
        end else if (c inside {[8'h61:8'h7a]}) begin
            s.value = c - CH_LOWER + 8'd26;
        end else if (c inside {[8'h30:8'h39]}) begin
            s.value = c - CH_DIGIT + 8'd52;
        end else if (c == CH_PLUS) begin
            s.value = 8'd62;
        end else if (c == CH_SLASH) begin
            s.value = 8'd63;
        end else begin
            s.value = VAL_BAD;
            s.bad   = 1'b1;
        end
        return s;
    endfunction

    function automatic logic [2:0][7:0] group_bytes(input logic [7:0] v0, input logic [7:0] v1,
                                                    input logic [7:0] v2, input logic [7:0] v3);
        logic [2:0][7:0] b;
        b[0] = {v0[5:0], 2'b00} + ((v1 & MASK_HI2) >> 4);
        b[1] = {v1[3:0] & MASK_LO4[3:0], 4'b0000} + ((v2 & MASK_MID) >> 2);
        b[2] = {v2[1:0] & MASK_LO2[1:0], 6'b000000} + v3;
        return b;
    endfunction

endpackage

`default_nettype wire

// File: sv/b64d_if.sv
// b64d_char_if / b64d_byte_if: valid-ready channels of the base64 stream decoder
// no dependencies
`default_nettype none

interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic       bad_char_seen;

    modport source (output valid, output out_byte, output byte_valid,
                    output end_of_string, output bad_char_seen, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input end_of_string, input bad_char_seen, output ready);
endinterface

`default_nettype wire

// File: sv/b64d_front.sv
// b64d_front: takes characters, maps them to sextets, collects groups, builds result bundles
// depends on b64d_pkg and b64d_char_if
`default_nettype none

module b64d_front
    import b64d_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    b64d_char_if.sink    i_char,
    input  wire t_q_stat i_q_stat,
    output logic         o_push,
    output t_bundle      o_bundle
);

    logic [2:0][7:0] r_vals;
    logic [2:0][7:0] n_vals;
    logic [1:0]      r_phase;
    logic [1:0]      n_phase;
    logic            r_pad;
    logic            n_pad;
    logic            r_err;
    logic            n_err;
    logic            accept;
    logic            grp_full;
    logic            flush;
    t_sextet         sx;
    logic [7:0]      w1;
    logic [7:0]      w2;

    assign i_char.ready = !i_q_stat.full;
    assign accept       = i_char.valid && i_char.ready;

    always_comb begin
        sx       = sextet_of(i_char.in_char);
        n_vals   = r_vals;
        n_phase  = r_phase;
        n_pad    = r_pad;
        n_err    = r_err;
        grp_full = 1'b0;
        flush    = 1'b0;
        o_bundle = '0;

        if (!r_pad) begin
            if (i_char.in_char == CH_PAD) begin
                n_pad = 1'b1;
                flush = 1'b1;
            end else begin
                if (sx.bad) begin
                    n_err = 1'b1;
                end
                if (r_phase == 2'd3) begin
                    grp_full = 1'b1;
                    n_phase  = 2'd0;
                end else begin
                    n_vals[r_phase] = sx.value;
                    n_phase         = r_phase + 2'd1;
                end
            end
        end
        if (i_char.in_last) begin
            flush = 1'b1;
        end

        // partial group: n values give n-1 bytes
        w1 = (n_phase >= 2'd2) ? n_vals[1] : 8'd0;
        w2 = (n_phase == 2'd3) ? n_vals[2] : 8'd0;

        if (grp_full) begin
            o_bundle.bytes    = group_bytes(r_vals[0], r_vals[1], r_vals[2], sx.value);
            o_bundle.cnt      = 2'd3;
            o_bundle.has_data = 1'b1;
        end else if (flush && n_phase >= 2'd2) begin
            o_bundle.bytes    = group_bytes(n_vals[0], w1, w2, 8'd0);
            o_bundle.cnt      = n_phase - 2'd1;
            o_bundle.has_data = 1'b1;
        end else if (i_char.in_last) begin
            o_bundle.cnt      = 2'd1;
            o_bundle.has_data = 1'b0;
        end
        o_bundle.eos = i_char.in_last;
        o_bundle.err = n_err;

        if (flush) begin
            n_phase = 2'd0;
        end
        if (i_char.in_last) begin
            n_pad = 1'b0;
        end
    end

    assign o_push = accept && (o_bundle.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vals <= n_vals;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_pad   <= 1'b0;
            r_err   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pad   <= n_pad;
            r_err   <= n_err;
        end
    end

endmodule

`default_nettype wire

// File: sv/b64d_queue.sv
// b64d_queue: short bundle queue between the front and back parts
// depends on b64d_pkg
`default_nettype none

module b64d_queue
    import b64d_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_bundle i_data,
    input  wire logic    i_pop,
    output t_bundle      o_head,
    output t_q_stat      o_stat
);

    t_bundle           r_mem [QDepth];
    logic [QPtrW-1:0]  r_wr;
    logic [QPtrW-1:0]  r_rd;
    logic [QCntW-1:0]  r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_cnt == QCntW'(QDepth));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/b64d_back.sv
// b64d_back: unpacks bundles into single results behind an output register
// depends on b64d_pkg and b64d_byte_if
`default_nettype none

module b64d_back
    import b64d_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_bundle i_head,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    b64d_byte_if.source  o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_data;
    logic       r_eos;
    logic       r_err;
    logic [1:0] r_idx;
    logic       load;
    logic       at_end;

    assign load   = !i_q_stat.empty && (!r_valid || o_byte.ready);
    assign at_end = (r_idx == i_head.cnt - 2'd1);
    assign o_pop  = load && at_end;

    assign o_byte.valid         = r_valid;
    assign o_byte.out_byte      = r_byte;
    assign o_byte.byte_valid    = r_data;
    assign o_byte.end_of_string = r_eos;
    assign o_byte.bad_char_seen = r_err;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.has_data ? i_head.bytes[r_idx] : 8'd0;
            r_data <= i_head.has_data;
            r_eos  <= i_head.eos && at_end;
            r_err  <= i_head.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (o_byte.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/base64_stream_decoder.sv
// base64_stream_decoder: top level of the streaming base64 decoder
// depends on b64d_pkg, b64d_if, b64d_front, b64d_queue and b64d_back
//
// usage
//   i_char carries one encoded character per transfer, in_last flags the
//   final character of a string. o_byte carries one decoded byte per
//   transfer; byte_valid low marks a bare end marker, end_of_string is set
//   on the last result of each string, bad_char_seen is sticky until reset.
//   one character is taken per cycle while the queue is not full; a full
//   group of four gives three bytes, a padded or cut group of n characters
//   gives n-1 bytes. a bundle enters the four-entry queue at its transfer,
//   and the output register loads its results from the queue head when free.
//   while the receiver is ready, the output register emits one result per
//   cycle, so a group of four characters drains faster than it arrives and
//   the input keeps its full rate.
//   when the receiver stalls, results stay in the output register and the
//   queue; i_char.ready drops only once the queue is full.
//   synchronous reset clears group phase, pad and error state and empties
//   the queue; no clearing pass is needed.
`default_nettype none

module base64_stream_decoder
    import b64d_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    b64d_char_if.sink   i_char,
    b64d_byte_if.source o_byte
);

    logic    push;
    logic    pop;
    t_bundle push_data;
    t_bundle head;
    t_q_stat q_stat;

    b64d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (i_char),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_bundle (push_data)
    );

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    b64d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_byte   (o_byte)
    );

    // a bare marker always closes a string
    a_marker_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && !o_byte.byte_valid) |-> o_byte.end_of_string)
        else $error("end marker without end_of_string");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && !o_byte.byte_valid) |-> (o_byte.out_byte == 8'd0))
        else $error("end marker with nonzero byte");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && $past(o_byte.valid && o_byte.bad_char_seen)) |-> o_byte.bad_char_seen)
        else $error("bad_char_seen dropped");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("queue overflow");

endmodule

`default_nettype wire
